// ----- src/tlpf_pkg.sv -----
// Shared codes for the two-level priority FIFO.
// Command and status encodings used by the top level and its checker.
// No dependencies.
`default_nettype none

package tlpf_pkg;

	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_NORMAL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_URGENT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP = 2'd2;

	// High bit of cmd selects a pop.
	localparam int CMD_POP_BIT = 1;

	localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_POPPED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	// One accepted transaction waiting for its memory read to land.
	typedef struct packed {
		logic valid;
		logic [STATUS_W-1:0] status;
		logic urgent;
	} pend_t;

endpackage

`default_nettype wire

// ----- src/two_level_priority_fifo.sv -----
// Two-level priority FIFO: urgent and normal ring buffers of identifiers.
// Depends on tlpf_pkg for command and status codes.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd and item_id. cmd 0 pushes
//   into the normal ring, cmd 1 into the urgent ring, cmd 2 or 3 pops the
//   oldest urgent identifier, or the oldest normal one if urgent is empty.
//   Output channel (out_valid / out_stall) returns one result per transaction:
//   status, popped_id (zero unless a pop succeeded) and from_urgent.
//   Result path: the head entry is read at the accept edge, and the output
//   register loads from the read data once the pending stage can move on.
//   Throughput: one transaction per cycle while the receiver takes results.
//   Pointers and counts update at the accept edge, so a pop right after a
//   push sees the new entry; each ring has one write and one read port.
//   Stall: when out_stall holds a result, the pending stage fills and then
//   in_stall rises until the output register drains.
//   Reset: arst_n clears both rings to empty and drops out_valid. Ring
//   contents are not cleared; only written entries are ever read.
`default_nettype none

module two_level_priority_fifo #(
	parameter int FIFO_DEPTH = 8,
	parameter int ID_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic in_valid,
	output logic in_stall,
	input wire logic [tlpf_pkg::CMD_W-1:0] cmd,
	input wire logic [ID_BITS-1:0] item_id,

	output logic out_valid,
	input wire logic out_stall,
	output logic [tlpf_pkg::STATUS_W-1:0] status,
	output logic [ID_BITS-1:0] popped_id,
	output logic from_urgent
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
	localparam logic [AW-1:0] LAST_C = AW'(FIFO_DEPTH - 1);

	logic [ID_BITS-1:0] urg_mem [FIFO_DEPTH];
	logic [ID_BITS-1:0] nrm_mem [FIFO_DEPTH];
	logic [ID_BITS-1:0] urg_rd_q;
	logic [ID_BITS-1:0] nrm_rd_q;

	logic [AW-1:0] urg_head_q;
	logic [AW-1:0] nrm_head_q;
	logic [CW-1:0] urg_cnt_q;
	logic [CW-1:0] nrm_cnt_q;

	tlpf_pkg::pend_t pend_s1;
	tlpf_pkg::pend_t pend_d;

	logic out_valid_q;
	logic [tlpf_pkg::STATUS_W-1:0] status_q;
	logic [ID_BITS-1:0] popped_id_q;
	logic from_urgent_q;

	logic in_acc;
	logic move_s1;
	logic is_pop;
	logic is_urg_push;
	logic urg_nonempty;
	logic nrm_nonempty;
	logic urg_full;
	logic nrm_full;
	logic urg_we;
	logic nrm_we;
	logic urg_re;
	logic nrm_re;
	logic [CW-1:0] urg_sum;
	logic [CW-1:0] nrm_sum;
	logic [AW-1:0] urg_tail;
	logic [AW-1:0] nrm_tail;
	logic [ID_BITS-1:0] rd_sel;

	assign move_s1 = pend_s1.valid & (~out_valid_q | ~out_stall);
	assign in_stall = pend_s1.valid & out_valid_q & out_stall;
	assign in_acc = in_valid & ~in_stall;

	assign is_pop = cmd[tlpf_pkg::CMD_POP_BIT];
	assign is_urg_push = (cmd == tlpf_pkg::CMD_PUSH_URGENT);

	assign urg_nonempty = (urg_cnt_q != '0);
	assign nrm_nonempty = (nrm_cnt_q != '0);
	assign urg_full = (urg_cnt_q == DEPTH_C);
	assign nrm_full = (nrm_cnt_q == DEPTH_C);

	// Tail = (head + count) mod depth; the sum stays below twice the depth.
	assign urg_sum = {1'b0, urg_head_q} + urg_cnt_q;
	assign nrm_sum = {1'b0, nrm_head_q} + nrm_cnt_q;
	assign urg_tail = (urg_sum >= DEPTH_C) ? AW'(urg_sum - DEPTH_C) : urg_sum[AW-1:0];
	assign nrm_tail = (nrm_sum >= DEPTH_C) ? AW'(nrm_sum - DEPTH_C) : nrm_sum[AW-1:0];

	always_comb begin
		urg_we = 1'b0;
		nrm_we = 1'b0;
		urg_re = 1'b0;
		nrm_re = 1'b0;
		pend_d.valid = in_acc;
		pend_d.urgent = 1'b0;
		pend_d.status = tlpf_pkg::ST_PUSHED;
		if (is_pop) begin
			if (urg_nonempty) begin
				urg_re = in_acc;
				pend_d.urgent = 1'b1;
				pend_d.status = tlpf_pkg::ST_POPPED;
			end else if (nrm_nonempty) begin
				nrm_re = in_acc;
				pend_d.status = tlpf_pkg::ST_POPPED;
			end else begin
				pend_d.status = tlpf_pkg::ST_EMPTY;
			end
		end else if (is_urg_push) begin
			if (urg_full) begin
				pend_d.status = tlpf_pkg::ST_FULL;
			end else begin
				urg_we = in_acc;
			end
		end else begin
			if (nrm_full) begin
				pend_d.status = tlpf_pkg::ST_FULL;
			end else begin
				nrm_we = in_acc;
			end
		end
	end

	// Ring memories: each has one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (urg_we) begin
			urg_mem[urg_tail] <= item_id;
		end
		if (urg_re) begin
			urg_rd_q <= urg_mem[urg_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (nrm_we) begin
			nrm_mem[nrm_tail] <= item_id;
		end
		if (nrm_re) begin
			nrm_rd_q <= nrm_mem[nrm_head_q];
		end
	end

	// Pointers advance at the accept edge so the next transaction sees them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urg_head_q <= '0;
			nrm_head_q <= '0;
			urg_cnt_q <= '0;
			nrm_cnt_q <= '0;
		end else begin
			if (urg_we) begin
				urg_cnt_q <= urg_cnt_q + CW'(1);
			end else if (urg_re) begin
				urg_cnt_q <= urg_cnt_q - CW'(1);
				urg_head_q <= (urg_head_q == LAST_C) ? '0 : urg_head_q + AW'(1);
			end
			if (nrm_we) begin
				nrm_cnt_q <= nrm_cnt_q + CW'(1);
			end else if (nrm_re) begin
				nrm_cnt_q <= nrm_cnt_q - CW'(1);
				nrm_head_q <= (nrm_head_q == LAST_C) ? '0 : nrm_head_q + AW'(1);
			end
		end
	end

	// Pending stage: hold while the output register is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (in_acc) begin
			pend_s1 <= pend_d;
		end else if (move_s1) begin
			pend_s1.valid <= 1'b0;
		end
	end

	assign rd_sel = pend_s1.urgent ? urg_rd_q : nrm_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			status_q <= pend_s1.status;
			from_urgent_q <= pend_s1.urgent;
			popped_id_q <= (pend_s1.status == tlpf_pkg::ST_POPPED) ? rd_sel : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign popped_id = popped_id_q;
	assign from_urgent = from_urgent_q;

endmodule

`default_nettype wire

// ----- src/tlpf_checker.sv -----
// Port-level checks for the two-level priority FIFO.
// Depends on tlpf_pkg; bound to two_level_priority_fifo below.
`default_nettype none

module tlpf_checker #(
	parameter int ID_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [tlpf_pkg::STATUS_W-1:0] status,
	input wire logic [ID_BITS-1:0] popped_id,
	input wire logic from_urgent
);

	// No result may be presented right after reset was seen.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result presented right after reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(popped_id) && $stable(from_urgent))
		else $error("stalled result changed");

	// Only a successful pop carries an identifier or the urgent flag.
	a_push_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != tlpf_pkg::ST_POPPED) |-> popped_id == '0 && !from_urgent)
		else $error("non-pop result carries pop data");

	a_urg_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && from_urgent |-> status == tlpf_pkg::ST_POPPED)
		else $error("urgent flag without a pop");

endmodule

bind two_level_priority_fifo tlpf_checker #(.ID_BITS(ID_BITS)) u_tlpf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.popped_id(popped_id),
	.from_urgent(from_urgent)
);

`default_nettype wire
